FILE: rtl/core/char_lcd_nibble_interface_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD nibble interface unit
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_INTERFACE_UNIT_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a condition holds at every rising clock edge
`define CLNU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a condition in one cycle implies another in the next
`define CLNU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CLNU_ASSERT_ALWAYS(label, cond, msg)
`define CLNU_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

FILE: rtl/core/clnu_pkg.sv
// ----------------------------------------------------------------------------
// clnu_pkg
// Types, codes and sequencing functions of the character LCD nibble unit.
// ----------------------------------------------------------------------------
package clnu_pkg;

    // Request actions
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_CHAR    = 3'd1,
        ACT_COMMAND = 3'd2,
        ACT_CURSOR  = 3'd3,
        ACT_CLEAR   = 3'd4,
        ACT_INIT    = 3'd5
    } lcd_action_t;

    // Configuration register indexes
    localparam logic [2:0] REG_STROBE     = 3'd0;
    localparam logic [2:0] REG_BYTE_GAP   = 3'd1;
    localparam logic [2:0] REG_CLEAR_WAIT = 3'd2;
    localparam logic [2:0] REG_POWER_UP   = 3'd3;
    localparam logic [2:0] REG_FUNC_SET   = 3'd4;
    localparam logic [2:0] REG_INIT_STEP  = 3'd5;

    // Byte transfer phases
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_POWER  = 4'd1,
        PH_LOW    = 4'd2,
        PH_HSET   = 4'd3,
        PH_HPULSE = 4'd4,
        PH_HHOLD  = 4'd5,
        PH_LSET   = 4'd6,
        PH_LPULSE = 4'd7,
        PH_GAP    = 4'd8,
        PH_EXTRA  = 4'd9,
        PH_DONE   = 4'd10
    } lcd_phase_t;

    // Display command bytes
    localparam logic [7:0] CMD_LINE0_BASE = 8'h80;
    localparam logic [7:0] CMD_LINE1_BASE = 8'hC0;
    localparam logic [7:0] CMD_FUNC_8BIT  = 8'h30;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;

    // Pin vector layout: {enable, select, D7..D4}
    localparam logic [5:0] PIN_RS = 6'h10;
    localparam logic [5:0] PIN_E  = 6'h20;

    typedef struct packed {
        logic [7:0]  strobe_ticks;
        logic [15:0] byte_gap_ticks;
        logic [15:0] clear_wait_ticks;
        logic [15:0] power_up_wait_ticks;
        logic [15:0] function_set_wait_ticks;
        logic [15:0] init_step_wait_ticks;
    } lcd_cfg_t;

    typedef struct packed {
        lcd_phase_t  phase;
        logic [15:0] wait_count;
        logic [7:0]  held_byte;
        logic        held_select;
        logic [2:0]  script_step;
        logic [15:0] extra_wait;
        logic [5:0]  pin_levels;
    } lcd_state_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic [5:0] column;
        logic       row;
    } lcd_req_t;

    typedef struct packed {
        logic [3:0] data_pins;
        logic       reg_select;
        logic       enable;
        logic       busy_res;
        logic       refused;
    } lcd_res_t;

    // Load one byte of the power-up script with its own extra wait
    function automatic lcd_state_t load_script(lcd_state_t s, logic [2:0] idx, lcd_cfg_t c);
        lcd_state_t r;
        r = s;
        r.held_select = 1'b0;
        case (idx)
            3'd0, 3'd1, 3'd2:
            begin
                r.held_byte  = CMD_FUNC_8BIT;
                r.extra_wait = c.function_set_wait_ticks;
            end
            3'd3:
            begin
                r.held_byte  = CMD_FUNC_4BIT;
                r.extra_wait = c.init_step_wait_ticks;
            end
            3'd4:
            begin
                r.held_byte  = CMD_DISPLAY_ON;
                r.extra_wait = c.init_step_wait_ticks;
            end
            3'd5:
            begin
                r.held_byte  = CMD_CLEAR;
                r.extra_wait = c.clear_wait_ticks;
            end
            default:
            begin
                r.held_byte  = CMD_ENTRY_MODE;
                r.extra_wait = c.init_step_wait_ticks;
            end
        endcase
        return r;
    endfunction

    // Enter a phase, skipping empty waits and chaining script bytes
    function automatic lcd_state_t enter_phase(lcd_state_t s, lcd_phase_t p, lcd_cfg_t c);
        lcd_state_t r;
        lcd_phase_t q;
        logic [7:0] st;
        logic [5:0] rs;
        logic [5:0] up;
        logic [5:0] lo;
        r = s;
        q = p;
        if (q == PH_POWER && c.power_up_wait_ticks == 16'd0)
            q = PH_LOW;
        if (q == PH_GAP && c.byte_gap_ticks == 16'd0)
            q = PH_EXTRA;
        if (q == PH_EXTRA && r.extra_wait == 16'd0)
            q = PH_DONE;
        // Chain to the next script byte once one finishes
        if (q == PH_DONE && r.script_step >= 3'd1 && r.script_step <= 3'd6)
        begin
            r = load_script(r, r.script_step, c);
            r.script_step = r.script_step + 3'd1;
            q = PH_LOW;
        end
        st = (c.strobe_ticks == 8'd0) ? 8'd1 : c.strobe_ticks;
        rs = r.held_select ? PIN_RS : 6'h00;
        up = {2'b00, r.held_byte[7:4]};
        lo = {2'b00, r.held_byte[3:0]};
        r.phase = q;
        case (q)
            PH_POWER:
                r.wait_count = c.power_up_wait_ticks;
            PH_LOW:
            begin
                r.wait_count = 16'd1;
                r.pin_levels = 6'h00;
            end
            PH_HSET, PH_HHOLD:
            begin
                r.wait_count = {8'd0, st};
                r.pin_levels = up | rs;
            end
            PH_HPULSE:
            begin
                r.wait_count = {8'd0, st};
                r.pin_levels = up | rs | PIN_E;
            end
            PH_LSET:
            begin
                r.wait_count = {8'd0, st};
                r.pin_levels = lo | rs;
            end
            PH_LPULSE:
            begin
                r.wait_count = {8'd0, st};
                r.pin_levels = lo | rs | PIN_E;
            end
            PH_GAP:
            begin
                r.wait_count = c.byte_gap_ticks;
                r.pin_levels = lo | rs;
            end
            PH_EXTRA:
            begin
                r.wait_count = r.extra_wait;
                r.pin_levels = lo | rs;
            end
            default:
            begin
                r.phase       = PH_IDLE;
                r.script_step = 3'd0;
                r.wait_count  = 16'd0;
                r.pin_levels  = r.pin_levels & ~PIN_E;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/clnu_channels.sv
// ----------------------------------------------------------------------------
// clnu channels
// Valid/ready request and result channels of the character LCD nibble unit.
// ----------------------------------------------------------------------------
interface clnu_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [5:0] column;
    logic       row;

    modport source (output valid, output action, output data_byte, output column,
                    output row, input ready);
    modport sink (input valid, input action, input data_byte, input column,
                  input row, output ready);
endinterface

interface clnu_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] data_pins;
    logic       reg_select;
    logic       enable;
    logic       busy_res;
    logic       refused;

    modport source (output valid, output data_pins, output reg_select, output enable,
                    output busy_res, output refused, input ready);
    modport sink (input valid, input data_pins, input reg_select, input enable,
                  input busy_res, input refused, output ready);
endinterface

FILE: rtl/core/char_lcd_nibble_interface_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_unit
// Character LCD controller for a 4-bit bus, stepped by microsecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per microsecond: a plain tick, or a request to write
//   a character, write a command, move the cursor, clear, or run the power-up
//   script. Each accepted item yields exactly one result on res with the pin
//   levels for that tick, the busy flag, and a refused flag for a request that
//   arrived while a transfer was still running (it is dropped).
//   res.valid rises in the cycle after acceptance; one item is taken in every
//   cycle unless res stalls, via the single-step sequencer feeding the result
//   register. req.ready stays high while the result register is empty or is
//   being taken, so a stalled receiver holds the result and stops intake.
//   The APB port writes the six timing registers at byte addresses 4*i; the user
//   must write them only while the block is idle (not enforced by the block);
//   reads return the stored values. Reset puts the sequencer idle with all pins
//   low and the timing registers at their defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_interface_unit_defines.svh"

module char_lcd_nibble_interface_unit
    import clnu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    clnu_req_if.sink    req,
    clnu_res_if.source  res
);

    lcd_cfg_t   cfg_reg;
    lcd_cfg_t   cfg_next;
    lcd_req_t   step_req;
    lcd_res_t   step_res;
    lcd_res_t   res_data_reg;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       accept;
    logic       cfg_write;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                REG_STROBE:     cfg_next.strobe_ticks            = pwdata[7:0];
                REG_BYTE_GAP:   cfg_next.byte_gap_ticks          = pwdata[15:0];
                REG_CLEAR_WAIT: cfg_next.clear_wait_ticks        = pwdata[15:0];
                REG_POWER_UP:   cfg_next.power_up_wait_ticks     = pwdata[15:0];
                REG_FUNC_SET:   cfg_next.function_set_wait_ticks = pwdata[15:0];
                REG_INIT_STEP:  cfg_next.init_step_wait_ticks    = pwdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Return register values on reads
    always_comb
    begin
        case (reg_index)
            REG_STROBE:     prdata = {24'd0, cfg_reg.strobe_ticks};
            REG_BYTE_GAP:   prdata = {16'd0, cfg_reg.byte_gap_ticks};
            REG_CLEAR_WAIT: prdata = {16'd0, cfg_reg.clear_wait_ticks};
            REG_POWER_UP:   prdata = {16'd0, cfg_reg.power_up_wait_ticks};
            REG_FUNC_SET:   prdata = {16'd0, cfg_reg.function_set_wait_ticks};
            REG_INIT_STEP:  prdata = {16'd0, cfg_reg.init_step_wait_ticks};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{strobe_ticks: 8'd1, byte_gap_ticks: 16'd1000,
                         clear_wait_ticks: 16'd5000, power_up_wait_ticks: 16'd15000,
                         function_set_wait_ticks: 16'd10000,
                         init_step_wait_ticks: 16'd1000};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept a request while the result slot is free or draining
    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    assign step_req.action    = req.action;
    assign step_req.data_byte = req.data_byte;
    assign step_req.column    = req.column;
    assign step_req.row       = req.row;

    clnu_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (accept),
        .req     (step_req),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    // Hold the result until the receiver takes it
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_data_reg <= step_res;
    end

    assign res.valid      = res_valid_reg;
    assign res.data_pins  = res_data_reg.data_pins;
    assign res.reg_select = res_data_reg.reg_select;
    assign res.enable     = res_data_reg.enable;
    assign res.busy_res   = res_data_reg.busy_res;
    assign res.refused    = res_data_reg.refused;

    // Checks
    `CLNU_ASSERT_NEXT(a_accept_fills, accept, res_valid_reg, "accepted request left no result")
    `CLNU_ASSERT_ALWAYS(a_refused_busy, !res_valid_reg || !res_data_reg.refused || res_data_reg.busy_res, "refused while idle")
    `CLNU_ASSERT_ALWAYS(a_enable_busy, !res_valid_reg || !res_data_reg.enable || res_data_reg.busy_res, "enable high while idle")

endmodule

FILE: rtl/core/clnu_engine.sv
// ----------------------------------------------------------------------------
// clnu_engine
// Transfer sequencer: takes one request or tick per step and advances time.
// ----------------------------------------------------------------------------
module clnu_engine
    import clnu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step_en,
    input  lcd_req_t req,
    input  lcd_cfg_t cfg,
    output lcd_res_t res
);

    lcd_state_t state_reg;
    lcd_state_t state_next;
    lcd_state_t s_req;
    lcd_state_t s_adv;
    logic       refused;
    logic       busy;
    logic [7:0] cursor_addr;
    logic [15:0] wait_dec;

    assign cursor_addr = (req.row ? CMD_LINE1_BASE : CMD_LINE0_BASE) + {2'b00, req.column};

    // Start a request when idle, flag it when busy
    always_comb
    begin
        s_req   = state_reg;
        refused = 1'b0;
        if (req.action >= ACT_CHAR && req.action <= ACT_INIT)
        begin
            if (state_reg.phase != PH_IDLE)
            begin
                refused = 1'b1;
            end
            else
            begin
                s_req.script_step = 3'd0;
                s_req.held_select = 1'b0;
                s_req.extra_wait  = 16'd0;
                case (lcd_action_t'(req.action))
                    ACT_CHAR:
                    begin
                        s_req.held_byte   = req.data_byte;
                        s_req.held_select = 1'b1;
                        s_req = enter_phase(s_req, PH_LOW, cfg);
                    end
                    ACT_COMMAND:
                    begin
                        s_req.held_byte = req.data_byte;
                        s_req = enter_phase(s_req, PH_LOW, cfg);
                    end
                    ACT_CURSOR:
                    begin
                        s_req.held_byte = cursor_addr;
                        s_req = enter_phase(s_req, PH_LOW, cfg);
                    end
                    ACT_CLEAR:
                    begin
                        s_req.held_byte  = CMD_CLEAR;
                        s_req.extra_wait = cfg.clear_wait_ticks;
                        s_req = enter_phase(s_req, PH_LOW, cfg);
                    end
                    default:
                    begin
                        s_req.script_step = 3'd1;
                        s_req = load_script(s_req, 3'd0, cfg);
                        s_req = enter_phase(s_req, PH_POWER, cfg);
                    end
                endcase
            end
        end
    end

    assign busy     = (s_req.phase != PH_IDLE);
    assign wait_dec = (s_req.wait_count != 16'd0) ? s_req.wait_count - 16'd1 : 16'd0;

    // Advance the running phase by one tick
    always_comb
    begin
        s_adv = s_req;
        if (busy)
        begin
            s_adv.wait_count = wait_dec;
            if (wait_dec == 16'd0)
                s_adv = enter_phase(s_req, lcd_phase_t'(s_req.phase + 4'd1), cfg);
        end
    end

    // Drive the levels of this tick
    always_comb
    begin
        res.data_pins  = s_req.pin_levels[3:0];
        res.reg_select = s_req.pin_levels[4];
        res.enable     = s_req.pin_levels[5];
        res.busy_res   = busy;
        res.refused    = refused;
    end

    assign state_next = step_en ? s_adv : state_reg;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, wait_count: 16'd0, held_byte: 8'd0,
                           held_select: 1'b0, script_step: 3'd0, extra_wait: 16'd0,
                           pin_levels: 6'd0};
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Character LCD nibble interface unit testbench
// Feeds microsecond ticks and display requests through the valid/ready request
// channel, predicts the bus pin levels, busy and refused flags of every tick,
// and compares each result field by field. The timing registers are written
// over APB between phases, read back, and driven through their extremes.
// ----------------------------------------------------------------------------
module tb;
    import clnu_pkg::*;

    // Codes outside the defined request set, taken as plain ticks
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 100000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    clnu_req_if req_ch ();
    clnu_res_if res_ch ();

    char_lcd_nibble_interface_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    // Predicted bus sequencer and its timing registers
    lcd_cfg_t    timing;
    lcd_phase_t  bus_phase;
    logic [15:0] bus_wait;
    logic [7:0]  bus_byte;
    logic        bus_rs;
    logic [2:0]  bus_script;
    logic [15:0] bus_extra;
    logic [5:0]  bus_pins;

    lcd_res_t    expected_pins_q[$];
    lcd_res_t    want;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          sender_gaps = 1'b1;
    int unsigned rx_mode = 0;
    int unsigned rx_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Load one power-up script command with its own extra wait
    task automatic load_script_command(input logic [2:0] idx);
        bus_rs = 1'b0;
        case (idx)
            3'd0, 3'd1, 3'd2:
            begin
                bus_byte  = CMD_FUNC_8BIT;
                bus_extra = timing.function_set_wait_ticks;
            end
            3'd3:
            begin
                bus_byte  = CMD_FUNC_4BIT;
                bus_extra = timing.init_step_wait_ticks;
            end
            3'd4:
            begin
                bus_byte  = CMD_DISPLAY_ON;
                bus_extra = timing.init_step_wait_ticks;
            end
            3'd5:
            begin
                bus_byte  = CMD_CLEAR;
                bus_extra = timing.clear_wait_ticks;
            end
            default:
            begin
                bus_byte  = CMD_ENTRY_MODE;
                bus_extra = timing.init_step_wait_ticks;
            end
        endcase
    endtask

    // Enter a phase: skip empty waits, chain script commands, drop to idle
    task automatic enter_bus_phase(input lcd_phase_t start);
        lcd_phase_t  p;
        logic [5:0]  rs;
        logic [5:0]  up;
        logic [5:0]  lo;
        logic [7:0]  st;
        logic [15:0] len;
        bit          done;
        p = start;
        done = 1'b0;
        while (!done)
        begin
            rs = bus_rs ? PIN_RS : 6'h00;
            up = {2'b00, bus_byte[7:4]};
            lo = {2'b00, bus_byte[3:0]};
            st = (timing.strobe_ticks == 8'd0) ? 8'd1 : timing.strobe_ticks;
            if (p >= PH_DONE)
            begin
                if (bus_script >= 3'd1 && bus_script <= 3'd6)
                begin
                    bus_script = bus_script + 3'd1;
                    load_script_command(bus_script - 3'd1);
                    p = PH_LOW;
                end
                else
                begin
                    bus_script = 3'd0;
                    bus_phase  = PH_IDLE;
                    bus_wait   = 16'd0;
                    bus_pins   = bus_pins & ~PIN_E;
                    done       = 1'b1;
                end
            end
            else
            begin
                case (p)
                    PH_POWER:
                        len = timing.power_up_wait_ticks;
                    PH_LOW:
                    begin
                        len = 16'd1;
                        bus_pins = 6'h00;
                    end
                    PH_HSET, PH_HHOLD:
                    begin
                        len = {8'd0, st};
                        bus_pins = up | rs;
                    end
                    PH_HPULSE:
                    begin
                        len = {8'd0, st};
                        bus_pins = up | rs | PIN_E;
                    end
                    PH_LSET:
                    begin
                        len = {8'd0, st};
                        bus_pins = lo | rs;
                    end
                    PH_LPULSE:
                    begin
                        len = {8'd0, st};
                        bus_pins = lo | rs | PIN_E;
                    end
                    PH_GAP:
                    begin
                        len = timing.byte_gap_ticks;
                        bus_pins = lo | rs;
                    end
                    default:
                    begin
                        len = bus_extra;
                        bus_pins = lo | rs;
                    end
                endcase
                if (len != 16'd0)
                begin
                    bus_phase = p;
                    bus_wait  = len;
                    done      = 1'b1;
                end
                else
                    p = lcd_phase_t'(p + 1);
            end
        end
    endtask

    task automatic start_byte(input logic [7:0] b, input logic sel, input logic [15:0] extra);
        bus_byte   = b;
        bus_rs     = sel;
        bus_extra  = extra;
        bus_script = 3'd0;
        enter_bus_phase(PH_LOW);
    endtask

    // Work out the pin levels and flags of one tick, then advance time
    task automatic predict_lcd_tick(input lcd_req_t item, output lcd_res_t r);
        logic       refused;
        logic [7:0] address;
        refused = 1'b0;
        if (item.action >= ACT_CHAR && item.action <= ACT_INIT)
        begin
            if (bus_phase != PH_IDLE)
                refused = 1'b1;
            else
            begin
                case (lcd_action_t'(item.action))
                    ACT_CHAR:
                        start_byte(item.data_byte, 1'b1, 16'd0);
                    ACT_COMMAND:
                        start_byte(item.data_byte, 1'b0, 16'd0);
                    ACT_CURSOR:
                    begin
                        address = (item.row ? CMD_LINE1_BASE : CMD_LINE0_BASE)
                                  + {2'b00, item.column};
                        start_byte(address, 1'b0, 16'd0);
                    end
                    ACT_CLEAR:
                        start_byte(CMD_CLEAR, 1'b0, timing.clear_wait_ticks);
                    default:
                    begin
                        bus_script = 3'd1;
                        load_script_command(3'd0);
                        enter_bus_phase(PH_POWER);
                    end
                endcase
            end
        end
        r.data_pins  = bus_pins[3:0];
        r.reg_select = bus_pins[4];
        r.enable     = bus_pins[5];
        r.busy_res   = (bus_phase != PH_IDLE);
        r.refused    = refused;
        if (bus_phase != PH_IDLE)
        begin
            if (bus_wait != 16'd0)
                bus_wait = bus_wait - 16'd1;
            if (bus_wait == 16'd0)
                enter_bus_phase(lcd_phase_t'(bus_phase + 1));
        end
    endtask

    // Send one request, idling between bursts, and record its expected pins
    task automatic send_request(input lcd_req_t item);
        lcd_res_t expected;
        if (burst_left == 0)
        begin
            if (sender_gaps)
                repeat ($urandom_range(1, 4)) @(negedge clk) req_ch.valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.action    <= item.action;
        req_ch.data_byte <= item.data_byte;
        req_ch.column    <= item.column;
        req_ch.row       <= item.row;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_lcd_tick(item, expected);
        expected_pins_q.push_back(expected);
        burst_left--;
    endtask

    task automatic issue(input logic [2:0] a, input logic [7:0] d, input logic [5:0] c,
                         input logic r);
        lcd_req_t item;
        item.action    = a;
        item.data_byte = d;
        item.column    = c;
        item.row       = r;
        send_request(item);
    endtask

    task automatic send_tick();
        issue(ACT_TICK, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
              1'($urandom_range(0, 1)));
    endtask

    // Advance time until the running job is over
    task automatic finish_job();
        while (bus_phase != PH_IDLE)
            send_tick();
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        @(negedge clk) req_ch.valid <= 1'b0;
        while (expected_pins_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic quiesce();
        finish_job();
        drain_results();
        repeat (2) @(posedge clk);
    endtask

    task automatic write_timing(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(negedge clk) penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_STROBE:     timing.strobe_ticks = value[7:0];
            REG_BYTE_GAP:   timing.byte_gap_ticks = value;
            REG_CLEAR_WAIT: timing.clear_wait_ticks = value;
            REG_POWER_UP:   timing.power_up_wait_ticks = value;
            REG_FUNC_SET:   timing.function_set_wait_ticks = value;
            default:        timing.init_step_wait_ticks = value;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all_timing(input logic [7:0] strobe, input logic [15:0] gap,
                                    input logic [15:0] clear_wait, input logic [15:0] power,
                                    input logic [15:0] func_set, input logic [15:0] step);
        write_timing(REG_STROBE, {8'd0, strobe});
        write_timing(REG_BYTE_GAP, gap);
        write_timing(REG_CLEAR_WAIT, clear_wait);
        write_timing(REG_POWER_UP, power);
        write_timing(REG_FUNC_SET, func_set);
        write_timing(REG_INIT_STEP, step);
    endtask

    // Read every timing register and compare with the stored value
    task automatic check_timing_readback();
        logic [31:0] want_value;
        logic [31:0] got_value;
        for (int i = 0; i <= int'(REG_INIT_STEP); i++)
        begin
            case (3'(i))
                REG_STROBE:     want_value = {24'd0, timing.strobe_ticks};
                REG_BYTE_GAP:   want_value = {16'd0, timing.byte_gap_ticks};
                REG_CLEAR_WAIT: want_value = {16'd0, timing.clear_wait_ticks};
                REG_POWER_UP:   want_value = {16'd0, timing.power_up_wait_ticks};
                REG_FUNC_SET:   want_value = {16'd0, timing.function_set_wait_ticks};
                default:        want_value = {16'd0, timing.init_step_wait_ticks};
            endcase
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {3'(i), 2'b00};
            @(negedge clk) penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            got_value = prdata;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got_value !== want_value)
            begin
                $error("prdata of register %0d: expected %0h, actual %0h", i, want_value,
                       got_value);
                error_count++;
            end
        end
    endtask

    function automatic logic [15:0] short_wait();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(6, 40));
        return 16'($urandom_range(0, 4));
    endfunction

    function automatic lcd_req_t random_request();
        lcd_req_t item;
        int unsigned pick;
        pick           = $urandom_range(0, 19);
        item.data_byte = 8'($urandom_range(0, 255));
        item.column    = 6'($urandom_range(0, 63));
        item.row       = 1'($urandom_range(0, 1));
        if (pick <= 5)
            item.action = ACT_CHAR;
        else if (pick <= 9)
            item.action = ACT_COMMAND;
        else if (pick <= 13)
            item.action = ACT_CURSOR;
        else if (pick <= 16)
            item.action = ACT_CLEAR;
        else if (pick <= 18)
            item.action = ACT_INIT;
        else
            item.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
        return item;
    endfunction

    // Defaults after reset: readback, idle ticks and unused action codes
    task automatic test_reset_defaults();
        check_timing_readback();
        repeat (3) send_tick();
        issue(ACT_SPARE6, 8'h41, 6'd0, 1'b0);
        issue(ACT_SPARE7, 8'hFF, 6'h3F, 1'b1);
        send_tick();
    endtask

    // Every request kind, refusals while busy and unused action codes
    task automatic test_directed_requests();
        quiesce();
        write_all_timing(8'd1, 16'd2, 16'd3, 16'd4, 16'd2, 16'd1);
        issue(ACT_CHAR, 8'hFF, 6'd0, 1'b0);
        send_tick();
        issue(ACT_CHAR, 8'h12, 6'd0, 1'b0);
        finish_job();
        issue(ACT_CHAR, 8'h00, 6'h3F, 1'b1);
        finish_job();
        issue(ACT_COMMAND, 8'hA5, 6'h15, 1'b0);
        issue(ACT_CURSOR, 8'h00, 6'h3F, 1'b1);
        finish_job();
        issue(ACT_COMMAND, 8'h5A, 6'h2A, 1'b1);
        finish_job();
        issue(ACT_CURSOR, 8'hFF, 6'd0, 1'b0);
        finish_job();
        issue(ACT_CURSOR, 8'h00, 6'h3F, 1'b1);
        finish_job();
        issue(ACT_CURSOR, 8'h00, 6'h3F, 1'b0);
        finish_job();
        issue(ACT_CLEAR, 8'hFF, 6'h3F, 1'b1);
        repeat (2) send_tick();
        issue(ACT_CLEAR, 8'h00, 6'd0, 1'b0);
        finish_job();
        issue(ACT_INIT, 8'h00, 6'd0, 1'b0);
        issue(ACT_INIT, 8'h00, 6'd0, 1'b0);
        repeat (9) send_tick();
        issue(ACT_COMMAND, 8'h0F, 6'd0, 1'b0);
        issue(ACT_SPARE6, 8'h10, 6'd0, 1'b0);
        finish_job();
        issue(ACT_SPARE6, 8'hFF, 6'h3F, 1'b1);
        issue(ACT_SPARE7, 8'h00, 6'd0, 1'b0);
        issue(ACT_CHAR, 8'h7E, 6'd0, 1'b0);
        finish_job();
    endtask

    // All waits zero, strobe zero held as one tick, back-to-back requests
    task automatic test_zero_waits();
        quiesce();
        write_all_timing(8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        issue(ACT_CHAR, 8'h3C, 6'd0, 1'b0);
        issue(ACT_COMMAND, 8'hC3, 6'd0, 1'b0);
        finish_job();
        issue(ACT_COMMAND, 8'hC3, 6'd0, 1'b0);
        finish_job();
        issue(ACT_CLEAR, 8'h00, 6'd0, 1'b0);
        finish_job();
        issue(ACT_INIT, 8'h00, 6'd0, 1'b0);
        finish_job();
        issue(ACT_CURSOR, 8'h00, 6'h3F, 1'b1);
        finish_job();
    endtask

    // Full-scale register values read back, then a long clear request
    task automatic test_longest_byte();
        quiesce();
        write_all_timing(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        check_timing_readback();
        write_all_timing(8'd10, 16'd60, 16'd50, 16'd0, 16'd0, 16'd0);
        sender_gaps = 1'b0;
        issue(ACT_CLEAR, 8'h00, 6'd0, 1'b0);
        repeat (60) send_tick();
        issue(ACT_CHAR, 8'h55, 6'd0, 1'b0);
        finish_job();
        sender_gaps = 1'b1;
    endtask

    // Long power-up and function set waits through the whole script
    task automatic test_longest_script();
        quiesce();
        write_all_timing(8'd1, 16'd0, 16'd0, 16'd30, 16'd20, 16'd0);
        sender_gaps = 1'b0;
        issue(ACT_INIT, 8'h00, 6'd0, 1'b0);
        finish_job();
        sender_gaps = 1'b1;
    endtask

    // Random requests over several short timing settings
    task automatic test_random_traffic();
        lcd_req_t    item;
        int unsigned sent;
        bit          try_request;
        for (int ph = 0; ph < 5; ph++)
        begin
            quiesce();
            write_all_timing(($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
                             short_wait(), short_wait(), short_wait(), short_wait(),
                             short_wait());
            sent = 0;
            while (sent < 65)
            begin
                if (bus_phase == PH_IDLE)
                    try_request = ($urandom_range(0, 3) != 0);
                else
                    try_request = ($urandom_range(0, 15) == 0);
                if (try_request)
                begin
                    item = random_request();
                    send_request(item);
                end
                else
                    send_tick();
                sent++;
                if ($urandom_range(0, 59) == 0)
                    drain_results();
            end
        end
    endtask

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_pins_q.size() == 0)
            begin
                $error("result taken with no request pending");
                error_count++;
            end
            else
            begin
                want = expected_pins_q.pop_front();
                if (res_ch.data_pins !== want.data_pins)
                begin
                    $error("data_pins: expected %0h, actual %0h", want.data_pins,
                           res_ch.data_pins);
                    error_count++;
                end
                if (res_ch.reg_select !== want.reg_select)
                begin
                    $error("reg_select: expected %0b, actual %0b", want.reg_select,
                           res_ch.reg_select);
                    error_count++;
                end
                if (res_ch.enable !== want.enable)
                begin
                    $error("enable: expected %0b, actual %0b", want.enable, res_ch.enable);
                    error_count++;
                end
                if (res_ch.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0b, actual %0b", want.busy_res,
                           res_ch.busy_res);
                    error_count++;
                end
                if (res_ch.refused !== want.refused)
                begin
                    $error("refused: expected %0b, actual %0b", want.refused, res_ch.refused);
                    error_count++;
                end
            end
        end
    end

    // Stall the result side in changing patterns
    always @(negedge clk)
    begin
        if (rx_count == 0)
        begin
            rx_mode  = $urandom_range(0, 3);
            rx_count = $urandom_range(16, 96);
        end
        rx_count--;
        case (rx_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       res_ch.ready <= (rx_count % 3 != 0);
            default: res_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = 5'd0;
        pwdata           = 32'd0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_TICK;
        req_ch.data_byte = 8'd0;
        req_ch.column    = 6'd0;
        req_ch.row       = 1'b0;
        res_ch.ready     = 1'b0;
        timing.strobe_ticks            = 8'd1;
        timing.byte_gap_ticks          = 16'd1000;
        timing.clear_wait_ticks        = 16'd5000;
        timing.power_up_wait_ticks     = 16'd15000;
        timing.function_set_wait_ticks = 16'd10000;
        timing.init_step_wait_ticks    = 16'd1000;
        bus_phase  = PH_IDLE;
        bus_wait   = 16'd0;
        bus_byte   = 8'd0;
        bus_rs     = 1'b0;
        bus_script = 3'd0;
        bus_extra  = 16'd0;
        bus_pins   = 6'd0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_requests();
        test_zero_waits();
        test_longest_byte();
        test_longest_script();
        test_random_traffic();

        quiesce();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/clnu_pkg.sv
rtl/core/clnu_channels.sv
rtl/core/clnu_engine.sv
rtl/core/char_lcd_nibble_interface_unit.sv
bench/tb.sv
